// ----- design/iccs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// IRC colour code stripper package
// Word types, control codes and character helpers shared by the stripper.
// ----------------------------------------------------------------------------
package iccs_pkg;

	// Control characters of the IRC formatting scheme.
	localparam logic [7:0] CHR_BOLD      = 8'h02;
	localparam logic [7:0] CHR_COLOUR    = 8'h03;
	localparam logic [7:0] CHR_BELL      = 8'h07;
	localparam logic [7:0] CHR_PLAIN     = 8'h0F;
	localparam logic [7:0] CHR_REVERSE   = 8'h16;
	localparam logic [7:0] CHR_UNDERLINE = 8'h1F;
	localparam logic [7:0] CHR_COMMA     = 8'h2C;
	localparam logic [7:0] CHR_DIGIT_LO  = 8'h30;
	localparam logic [7:0] CHR_DIGIT_HI  = 8'h39;

	// Largest number of digits dropped after a colour start or a comma.
	localparam logic [1:0] MAX_DIGITS    = 2'd2;

	// Input word.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_last;
	} iccs_in_t;

	// Output word.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_text;
	} iccs_out_t;

	// Words produced by one input word: up to two, in order.
	typedef struct packed {
		logic [1:0] cnt;
		iccs_out_t  w0;
		iccs_out_t  w1;
	} iccs_res_t;

	// Parser state, exported for checking.
	typedef struct packed {
		logic       colour_active;
		logic [1:0] digit_count;
		logic       comma_held;
	} iccs_state_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHR_DIGIT_LO) && (c <= CHR_DIGIT_HI);
	endfunction

	function automatic logic is_drop_code(input logic [7:0] c);
		return (c == CHR_BOLD) || (c == CHR_BELL) || (c == CHR_PLAIN) ||
			(c == CHR_REVERSE) || (c == CHR_UNDERLINE);
	endfunction

endpackage
`default_nettype wire

// ----- design/iccs_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// IRC colour code stripper: filter
// Parser state and the single-pass decision for one registered input word.
// ----------------------------------------------------------------------------
module iccs_filter
	import iccs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire iccs_in_t    item,
	input  wire logic        advance,
	output iccs_res_t        res,
	output iccs_state_t      status
);

	iccs_state_t st_q;
	iccs_state_t st_nxt;

	always_comb begin
		logic       dig;
		logic       comma_out;
		logic       char_out;
		logic       ca1;
		logic [1:0] dc1;
		iccs_out_t  wc;
		iccs_out_t  wb;

		dig       = is_digit(item.text_byte);
		comma_out = st_q.comma_held && !dig;
		ca1       = comma_out ? 1'b0 : st_q.colour_active;
		dc1       = (st_q.comma_held && dig) ? 2'd0 : st_q.digit_count;
		char_out  = 1'b0;

		st_nxt.colour_active = ca1;
		st_nxt.digit_count   = dc1;
		st_nxt.comma_held    = 1'b0;

		if (ca1 && dig && (dc1 < MAX_DIGITS)) begin
			st_nxt.digit_count = dc1 + 2'd1;
		end else if (ca1 && (item.text_byte == CHR_COMMA) && !item.is_last) begin
			st_nxt.comma_held = 1'b1;
		end else begin
			st_nxt.colour_active = 1'b0;
			if (item.text_byte == CHR_COLOUR) begin
				st_nxt.colour_active = 1'b1;
				st_nxt.digit_count   = 2'd0;
			end else if (!is_drop_code(item.text_byte)) begin
				char_out = 1'b1;
			end
		end

		wc = '{out_byte: CHR_COMMA,      byte_valid: 1'b1, end_of_text: 1'b0};
		wb = '{out_byte: item.text_byte, byte_valid: 1'b1, end_of_text: 1'b0};

		res.cnt = {1'b0, comma_out} + {1'b0, char_out};
		res.w0  = comma_out ? wc : wb;
		res.w1  = wb;

		if (item.is_last) begin
			// The end marker rides on the last word; a bare marker if none is kept.
			if (res.cnt == 2'd0) begin
				res.cnt = 2'd1;
				res.w0  = '{out_byte: 8'h00, byte_valid: 1'b0, end_of_text: 1'b1};
			end else if (res.cnt == 2'd2) begin
				res.w1.end_of_text = 1'b1;
			end else begin
				res.w0.end_of_text = 1'b1;
			end
			st_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	assign status = st_q;

endmodule
`default_nettype wire

// ----- design/iccs_out_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// IRC colour code stripper: output queue
// Two-entry shift queue that takes up to two words at once and hands one
// word per cycle to the output channel while out_ready is high.
// ----------------------------------------------------------------------------
module iccs_out_queue
	import iccs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire iccs_res_t  res,
	output logic [1:0]      free,
	output logic            out_valid,
	input  wire logic       out_ready,
	output iccs_out_t       out_data
);

	logic [1:0] count_q;
	iccs_out_t  entry_q [2];
	logic       pop;
	logic [1:0] kept;
	iccs_out_t  kept0;

	assign out_valid = (count_q != 2'd0);
	assign out_data  = entry_q[0];
	assign pop       = out_valid && out_ready;
	assign kept      = count_q - {1'b0, pop};
	assign kept0     = pop ? entry_q[1] : entry_q[0];
	assign free      = 2'd2 - kept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= kept + (push ? res.cnt : 2'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (kept != 2'd0) begin
			entry_q[0] <= kept0;
		end else begin
			entry_q[0] <= res.w0;
		end
		if (kept == 2'd2) begin
			entry_q[1] <= entry_q[1];
		end else if (kept == 2'd1) begin
			entry_q[1] <= res.w0;
		end else begin
			entry_q[1] <= res.w1;
		end
	end

endmodule
`default_nettype wire

// ----- design/irc_color_code_stripper_top.sv -----
`default_nettype none
// Path: an accepted word is registered in the input stage, then moves into
// the output queue, whose head drives out_data and out_valid.
// Throughput: one input word per cycle while the queue has room for its words;
// a word that releases a held comma together with itself yields two result words.
// Reset: arst_n clears the input stage, the parser state and the queue at once.
// ----------------------------------------------------------------------------
// IRC colour code stripper, top level
// Removes IRC colour and formatting codes from a byte stream, one byte per word.
// ----------------------------------------------------------------------------
module irc_color_code_stripper_top
	import iccs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire iccs_in_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output iccs_out_t      out_data
);

	// The input stage holds one word. It moves on into the filter state and the
	// output queue in a single pass once the queue has room for every word it
	// produces, so the input keeps flowing while a result waits to be taken.
	logic        valid_s1;
	iccs_in_t    item_s1;
	logic        advance;
	logic [1:0]  free;
	iccs_res_t   res;
	iccs_state_t status;

	assign advance  = valid_s1 && (res.cnt <= free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// The filter decides, from its state and the staged byte, which words leave.
	iccs_filter u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (advance),
		.res     (res),
		.status  (status)
	);

	// The queue absorbs the occasional pair of words that a released comma causes.
	iccs_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef SYNTH
	// A comma is only ever held while a colour code is being parsed.
	a_comma_in_colour: assert property (@(posedge clk) disable iff (!arst_n)
		status.comma_held |-> status.colour_active)
		else $error("comma held outside a colour code");

	// The digit allowance never goes beyond two.
	a_digit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		status.digit_count <= MAX_DIGITS)
		else $error("digit count beyond limit");

	// The end of a string returns the parser to its reset state.
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.is_last) |=> (status == '0))
		else $error("parser state not cleared after last word");
`endif

endmodule
`default_nettype wire
